// File: sv/bocr_pkg.sv
// ---------------------------------------------------------------------------
// bocr_pkg
// Shared constants and types for the Belady replacement unit.
// ---------------------------------------------------------------------------
package bocr_pkg;
  localparam int FUTURE_DEPTH = 1024;
  localparam int OBJECT_DEPTH = 256;
  localparam int FA_W = $clog2(FUTURE_DEPTH);
  localparam int OA_W = $clog2(OBJECT_DEPTH);
  localparam int FC_W = $clog2(FUTURE_DEPTH + 1);
  localparam int OCC_W = 64;
  localparam int CAP_W = 41;
  localparam logic [CAP_W-1:0] CAP_RESET = 41'd1048576;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DROP_RD,
    ST_DROP_WR,
    ST_INS,
    ST_OBJ_RD,
    ST_OBJ_CHK,
    ST_ADMIT,
    ST_EV_RD,
    ST_EV_CHK,
    ST_EV_OBJ_RD,
    ST_EV_OBJ_CHK,
    ST_EV_SHIFT_RD,
    ST_EV_SHIFT_WR,
    ST_DONE
  } state_t;
endpackage

// File: sv/bocr_ram.sv
// ---------------------------------------------------------------------------
// bocr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module bocr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/belady_optimal_cache_replacement_unit.sv
// Flow: entries for this request are dropped from the future table, the next use is
//   inserted and the object table scanned; a hit ends the scan early. An admission then
//   evicts the furthest next use until occupancy fits capacity or the table is empty.
// Handshake: one item at a time; busy stays high through the strobe cycle and the
//   receiver cannot stall. Scans share one read port per table.
// Reset (rst_n low, synchronous) empties both tables by clearing the fill count and
//   object valid bits; capacity returns to 1048576 bytes.
module belady_optimal_cache_replacement_unit
  import bocr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_object_id,
  input  logic [31:0] in_request_seq,
  input  logic [31:0] in_next_use_seq,
  input  logic [31:0] in_object_size,
  output logic        out_valid,
  output logic        out_hit,
  output logic        out_admitted,
  output logic        out_too_large,
  output logic [8:0]  out_evicted_count,
  output logic [40:0] out_occupied_bytes,
  output logic        out_table_full,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  state_t state_r, state_nxt;

  logic [CAP_W-1:0] cap_r;
  logic [31:0] id_r, seq_r, next_r, size_r;
  logic [FC_W-1:0] fcnt_r, fcnt_nxt;
  logic [FC_W-1:0] rd_r, rd_nxt, wr_r, wr_nxt, best_r, best_nxt;
  logic [31:0] bkey_r, bkey_nxt;
  logic [OA_W-1:0] oi_r, oi_nxt;
  logic [OA_W-1:0] free_r, free_nxt;
  logic free_ok_r, free_ok_nxt;
  logic [OBJECT_DEPTH-1:0] ovalid_r;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic hit_r, hit_nxt, adm_r, adm_nxt, tl_r, tl_nxt, full_r, full_nxt;
  logic [8:0] ev_r, ev_nxt;
  logic [31:0] vid_r, vid_nxt;

  // future table port
  logic f_we;
  logic [FA_W-1:0] f_waddr, f_raddr;
  logic [63:0] f_wdata, f_rdata;
  // object table port
  logic o_we;
  logic [OA_W-1:0] o_waddr, o_raddr;
  logic [63:0] o_wdata, o_rdata;
  logic o_set, o_clr;

  bocr_ram #(.WIDTH(64), .DEPTH(FUTURE_DEPTH)) u_fut (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata));
  bocr_ram #(.WIDTH(64), .DEPTH(OBJECT_DEPTH)) u_obj (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata));

  logic accept;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = paddr ? 64'd0 : {{(64-CAP_W){1'b0}}, cap_r};

  logic [OA_W-1:0] oi_idx;
  assign oi_idx = oi_r;
  logic o_match;
  assign o_match = ovalid_r[oi_idx] && (o_rdata[63:32] == vid_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:        if (accept) state_nxt = ST_DROP_RD;
      ST_DROP_RD:     if (rd_r == fcnt_r) state_nxt = ST_INS;
                      else state_nxt = ST_DROP_WR;
      ST_DROP_WR:     state_nxt = ST_DROP_RD;
      ST_INS:         state_nxt = ST_OBJ_RD;
      ST_OBJ_RD:      state_nxt = ST_OBJ_CHK;
      ST_OBJ_CHK: begin
        if (o_match) state_nxt = ST_DONE;
        else if (oi_r == OA_W'(OBJECT_DEPTH - 1)) begin
          if ({32'd0, size_r} > {23'd0, cap_r}) state_nxt = ST_DONE;
          else if (!free_ok_nxt) state_nxt = ST_DONE;
          else state_nxt = ST_ADMIT;
        end else state_nxt = ST_OBJ_RD;
      end
      ST_ADMIT:       state_nxt = ST_EV_RD;
      ST_EV_RD: begin
        if (occ_r <= {23'd0, cap_r} || fcnt_r == '0) state_nxt = ST_DONE;
        else if (rd_r == fcnt_r) state_nxt = ST_EV_OBJ_RD;
        else state_nxt = ST_EV_CHK;
      end
      ST_EV_CHK:      state_nxt = ST_EV_RD;
      ST_EV_OBJ_RD:   state_nxt = ST_EV_OBJ_CHK;
      ST_EV_OBJ_CHK: begin
        if (o_match || oi_r == OA_W'(OBJECT_DEPTH - 1)) state_nxt = ST_EV_SHIFT_RD;
        else state_nxt = ST_EV_OBJ_RD;
      end
      ST_EV_SHIFT_RD: if (rd_r >= fcnt_r) state_nxt = ST_EV_RD;
                      else state_nxt = ST_EV_SHIFT_WR;
      ST_EV_SHIFT_WR: state_nxt = ST_EV_SHIFT_RD;
      ST_DONE:        state_nxt = ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    fcnt_nxt = fcnt_r; rd_nxt = rd_r; wr_nxt = wr_r; best_nxt = best_r;
    bkey_nxt = bkey_r; oi_nxt = oi_r; free_nxt = free_r; free_ok_nxt = free_ok_r;
    occ_nxt = occ_r; hit_nxt = hit_r; adm_nxt = adm_r; tl_nxt = tl_r;
    full_nxt = full_r; ev_nxt = ev_r; vid_nxt = vid_r;
    f_we = 1'b0; f_waddr = wr_r[FA_W-1:0]; f_wdata = f_rdata;
    f_raddr = rd_r[FA_W-1:0];
    o_we = 1'b0; o_waddr = free_r; o_wdata = {id_r, size_r};
    o_raddr = oi_idx; o_set = 1'b0; o_clr = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        rd_nxt = '0; wr_nxt = '0; hit_nxt = 1'b0; adm_nxt = 1'b0;
        tl_nxt = 1'b0; full_nxt = 1'b0; ev_nxt = '0;
      end
      ST_DROP_RD: begin
        // read issued at rd_r; data visible next cycle
        if (rd_r == fcnt_r) fcnt_nxt = wr_r;
      end
      ST_DROP_WR: begin
        if (f_rdata[63:32] != seq_r) begin
          f_we = 1'b1;
          wr_nxt = wr_r + FC_W'(1);
        end
        rd_nxt = rd_r + FC_W'(1);
      end
      ST_INS: begin
        if (next_r != seq_r) begin
          if (fcnt_r < FC_W'(FUTURE_DEPTH)) begin
            f_we = 1'b1; f_waddr = fcnt_r[FA_W-1:0];
            f_wdata = {next_r, id_r};
            fcnt_nxt = fcnt_r + FC_W'(1);
          end else full_nxt = 1'b1;
        end
        oi_nxt = '0; free_ok_nxt = 1'b0; vid_nxt = id_r;
      end
      ST_OBJ_RD: ;
      ST_OBJ_CHK: begin
        if (!ovalid_r[oi_idx] && !free_ok_r) begin
          free_ok_nxt = 1'b1; free_nxt = oi_r;
        end
        if (o_match) hit_nxt = 1'b1;
        else if (oi_r == OA_W'(OBJECT_DEPTH - 1)) begin
          if ({32'd0, size_r} > {23'd0, cap_r}) tl_nxt = 1'b1;
          else if (!free_ok_nxt) full_nxt = 1'b1;
        end else oi_nxt = oi_r + OA_W'(1);
      end
      ST_ADMIT: begin
        o_we = 1'b1; o_set = 1'b1;
        occ_nxt = occ_r + {32'd0, size_r};
        adm_nxt = 1'b1;
        rd_nxt = '0; best_nxt = '0; bkey_nxt = '0;
      end
      ST_EV_RD: begin
        if (rd_r == fcnt_r) begin
          f_raddr = best_r[FA_W-1:0];
          oi_nxt = '0;
        end
      end
      ST_EV_CHK: begin
        // strict greater keeps the oldest among equal keys
        if (rd_r == '0 || f_rdata[63:32] > bkey_r) begin
          best_nxt = rd_r; bkey_nxt = f_rdata[63:32]; vid_nxt = f_rdata[31:0];
        end
        rd_nxt = rd_r + FC_W'(1);
      end
      ST_EV_OBJ_RD: ;
      ST_EV_OBJ_CHK: begin
        if (o_match) begin
          occ_nxt = occ_r - {32'd0, o_rdata[31:0]};
          o_clr = 1'b1;
          if (ev_r != 9'd511) ev_nxt = ev_r + 9'd1;
        end else oi_nxt = oi_r + OA_W'(1);
        if (o_match || oi_r == OA_W'(OBJECT_DEPTH - 1)) begin
          rd_nxt = best_r + FC_W'(1); wr_nxt = best_r;
        end
      end
      ST_EV_SHIFT_RD: begin
        if (rd_r >= fcnt_r) begin
          fcnt_nxt = fcnt_r - FC_W'(1);
          rd_nxt = '0; best_nxt = '0; bkey_nxt = '0;
        end
      end
      ST_EV_SHIFT_WR: begin
        f_we = 1'b1;
        wr_nxt = wr_r + FC_W'(1); rd_nxt = rd_r + FC_W'(1);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; cap_r <= CAP_RESET; fcnt_r <= '0; ovalid_r <= '0;
      occ_r <= '0;
    end else begin
      state_r <= state_nxt; fcnt_r <= fcnt_nxt; occ_r <= occ_nxt;
      if (psel && penable && pwrite && !paddr) cap_r <= pwdata[CAP_W-1:0];
      if (o_set) ovalid_r[free_r] <= 1'b1;
      if (o_clr) ovalid_r[oi_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_r <= in_object_id; seq_r <= in_request_seq;
      next_r <= in_next_use_seq; size_r <= in_object_size;
    end
    rd_r <= rd_nxt; wr_r <= wr_nxt; best_r <= best_nxt; bkey_r <= bkey_nxt;
    oi_r <= oi_nxt; free_r <= free_nxt; free_ok_r <= free_ok_nxt;
    hit_r <= hit_nxt; adm_r <= adm_nxt; tl_r <= tl_nxt; full_r <= full_nxt;
    ev_r <= ev_nxt; vid_r <= vid_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign out_hit = hit_r;
  assign out_admitted = adm_r;
  assign out_too_large = tl_r;
  assign out_evicted_count = ev_r;
  assign out_occupied_bytes = (occ_r[OCC_W-1:CAP_W] != '0) ? '1 : occ_r[CAP_W-1:0];
  assign out_table_full = full_r;
endmodule

// File: sv/bocr_checker.sv
// ---------------------------------------------------------------------------
// bocr_checker
// Port-level checks on the replacement unit.
// ---------------------------------------------------------------------------
module bocr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_hit,
  input logic       out_admitted,
  input logic       out_too_large,
  input logic [8:0] out_evicted_count
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("no busy after accept");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_hit, out_admitted, out_too_large}))
    else $error("flags overlap");
  a_ev_adm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_count != 9'd0 |-> out_admitted)
    else $error("eviction without admission");
endmodule

bind belady_optimal_cache_replacement_unit bocr_checker u_bocr_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_hit(out_hit), .out_admitted(out_admitted), .out_too_large(out_too_large),
  .out_evicted_count(out_evicted_count));
